// ===== hw/rtl/sofr_pkg.sv =====
// ----------------------------------------------------------------------------
// sofr_pkg
// Types, codes and the CRC-16/CCITT-FALSE byte update for the frame receiver.
// ----------------------------------------------------------------------------
package sofr_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [2:0]  HDR_LAST = 3'd5;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SECOND  = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC_LO  = 3'd4,
		PH_CRC_HI  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_VERSION = 3'd1,
		ERR_LENGTH  = 3'd2,
		ERR_CRC     = 3'd3,
		ERR_TIMEOUT = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       timed_out;
	} beat_t;

	typedef struct packed {
		logic [7:0]  start_marker_first;
		logic [7:0]  start_marker_second;
		logic [7:0]  expected_version;
		logic [15:0] payload_capacity;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [7:0]  frame_sequence;
		logic [15:0] frame_length;
		err_t        error_code;
	} result_t;

	localparam logic [1:0] CFG_MARKER_FIRST  = 2'd0;
	localparam logic [1:0] CFG_MARKER_SECOND = 2'd1;
	localparam logic [1:0] CFG_VERSION       = 2'd2;
	localparam logic [1:0] CFG_CAPACITY      = 2'd3;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/sofr_in_stage.sv =====
// ----------------------------------------------------------------------------
// sofr_in_stage
// Input register: captures one received beat and holds it for the parser.
// ----------------------------------------------------------------------------
module sofr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sofr_pkg::beat_t in_beat,
	output logic            beat_valid,
	input  logic            beat_ready,
	output sofr_pkg::beat_t beat
);
	import sofr_pkg::*;

	logic  valid_s1;
	beat_t beat_s1;

	assign in_ready   = !valid_s1 || beat_ready;
	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

// ===== hw/rtl/sofr_parser.sv =====
// ----------------------------------------------------------------------------
// sofr_parser
// Frame state machine, header capture, CRC check and result register.
// ----------------------------------------------------------------------------
module sofr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  sofr_pkg::cfg_t    cfg,
	input  logic              beat_valid,
	output logic              beat_ready,
	input  sofr_pkg::beat_t   beat,
	output logic              out_valid,
	input  logic              out_ready,
	output sofr_pkg::result_t result
);
	import sofr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d, hdr_idx_c;
	logic [47:0] hdr_q, hdr_d, hdr_ins;
	logic [15:0] remain_q, remain_d;
	logic [15:0] hcrc_q, hcrc_d;
	logic [15:0] pcrc_q, pcrc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] calc_crc;
	logic        hdr_last;
	logic        ver_bad, len_bad;
	logic        adv;
	logic        res_valid;
	kind_t       res_kind;
	logic [7:0]  res_pb;
	err_t        res_err;
	logic        out_valid_q;
	result_t     result_q;

	assign beat_ready = !out_valid_q || out_ready;
	assign adv        = beat_valid && beat_ready;
	assign out_valid  = out_valid_q;
	assign result     = result_q;

	assign hdr_idx_c = (hdr_idx_q > HDR_LAST) ? HDR_LAST : hdr_idx_q;
	assign hdr_last  = (hdr_idx_c == HDR_LAST);

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			hdr_ins[8*i +: 8] = hdr_q[8*i +: 8] |
				((hdr_idx_c == 3'(i)) ? beat.rx_byte : 8'h00);
		end
	end

	assign ver_bad  = (hdr_ins[7:0] != cfg.expected_version);
	assign len_bad  = (hdr_ins[47:32] > cfg.payload_capacity);
	assign calc_crc = (hdr_q[47:32] != 16'd0) ? (hcrc_q ^ pcrc_q) : hcrc_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (beat.timed_out) begin
			phase_d = PH_HUNT;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (beat.rx_byte == cfg.start_marker_first) phase_d = PH_SECOND;
				end
				PH_SECOND: begin
					phase_d = (beat.rx_byte == cfg.start_marker_second) ? PH_HEADER : PH_HUNT;
				end
				PH_HEADER: begin
					if (hdr_last) begin
						if (ver_bad || len_bad) begin
							phase_d = PH_HUNT;
						end else begin
							phase_d = (hdr_ins[47:32] != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
						end
					end
				end
				PH_PAYLOAD: begin
					if (remain_q == 16'd1) phase_d = PH_CRC_LO;
				end
				PH_CRC_LO: phase_d = PH_CRC_HI;
				PH_CRC_HI: phase_d = PH_HUNT;
				default:   phase_d = PH_HUNT;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		hdr_idx_d = hdr_idx_q;
		hdr_d     = hdr_q;
		remain_d  = remain_q;
		hcrc_d    = hcrc_q;
		pcrc_d    = pcrc_q;
		crc_lo_d  = crc_lo_q;
		res_valid = 1'b0;
		res_kind  = KIND_PAYLOAD;
		res_pb    = 8'h00;
		res_err   = ERR_NONE;
		if (beat.timed_out) begin
			if (phase_q != PH_HUNT && phase_q != PH_SECOND) begin
				res_valid = 1'b1;
				res_kind  = KIND_REJECT;
				res_err   = ERR_TIMEOUT;
			end
		end else begin
			case (phase_q)
				PH_SECOND: begin
					if (beat.rx_byte == cfg.start_marker_second) begin
						hdr_idx_d = 3'd0;
						hdr_d     = 48'd0;
						remain_d  = 16'd0;
						hcrc_d    = CRC_INIT;
						pcrc_d    = CRC_INIT;
					end
				end
				PH_HEADER: begin
					hdr_d  = hdr_ins;
					hcrc_d = crc_update(hcrc_q, beat.rx_byte);
					if (!hdr_last) begin
						hdr_idx_d = hdr_idx_c + 3'd1;
					end else begin
						hdr_idx_d = 3'd0;
						if (ver_bad) begin
							res_valid = 1'b1;
							res_kind  = KIND_REJECT;
							res_err   = ERR_VERSION;
						end else if (len_bad) begin
							res_valid = 1'b1;
							res_kind  = KIND_REJECT;
							res_err   = ERR_LENGTH;
						end else begin
							remain_d = hdr_ins[47:32];
						end
					end
				end
				PH_PAYLOAD: begin
					pcrc_d    = crc_update(pcrc_q, beat.rx_byte);
					remain_d  = remain_q - 16'd1;
					res_valid = 1'b1;
					res_pb    = beat.rx_byte;
				end
				PH_CRC_LO: begin
					crc_lo_d = beat.rx_byte;
				end
				PH_CRC_HI: begin
					res_valid = 1'b1;
					if (calc_crc == {beat.rx_byte, crc_lo_q}) begin
						res_kind = KIND_ACCEPT;
					end else begin
						res_kind = KIND_REJECT;
						res_err  = ERR_CRC;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hdr_idx_q <= 3'd0;
			hdr_q     <= 48'd0;
			remain_q  <= 16'd0;
			hcrc_q    <= CRC_INIT;
			pcrc_q    <= CRC_INIT;
			crc_lo_q  <= 8'h00;
		end else if (adv) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			hdr_q     <= hdr_d;
			remain_q  <= remain_d;
			hcrc_q    <= hcrc_d;
			pcrc_q    <= pcrc_d;
			crc_lo_q  <= crc_lo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.kind           <= res_kind;
			result_q.payload_byte   <= res_pb;
			result_q.frame_type     <= hdr_d[15:8];
			result_q.frame_flags    <= hdr_d[23:16];
			result_q.frame_sequence <= hdr_d[31:24];
			result_q.frame_length   <= hdr_d[47:32];
			result_q.error_code     <= res_err;
		end
	end

endmodule

// ===== hw/rtl/sof_length_crc_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sof_length_crc_frame_receiver_unit
// Start-marker / length / CRC-16 framed receiver; streams payload beats and
// closes each frame with an accept or reject verdict.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   in       | in_valid / in_ready     | rx_byte, timed_out
//   out      | out_valid / out_ready   | result_kind .. error_code
//   cfg      | cfg_write_en            | cfg_index, cfg_data
//
// One beat per cycle while the result sink keeps up; a beat's result passes
// through the input register, then parser logic into the result register.
// The per-beat CRC update sits in the single parser stage.
// A stalled result holds; the input register keeps taking one more beat.
// Reset returns to hunting with the register defaults.
// ----------------------------------------------------------------------------
module sof_length_crc_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        timed_out,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  frame_type,
	output logic [7:0]  frame_flags,
	output logic [7:0]  frame_sequence,
	output logic [15:0] frame_length,
	output logic [2:0]  error_code,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sofr_pkg::*;

	cfg_t    cfg_q;
	beat_t   in_beat, beat;
	logic    beat_valid, beat_ready;
	result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker_first  <= 8'h00;
			cfg_q.start_marker_second <= 8'h00;
			cfg_q.expected_version    <= 8'h01;
			cfg_q.payload_capacity    <= 16'hFFFF;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_MARKER_FIRST:  cfg_q.start_marker_first  <= cfg_data[7:0];
				CFG_MARKER_SECOND: cfg_q.start_marker_second <= cfg_data[7:0];
				CFG_VERSION:       cfg_q.expected_version    <= cfg_data[7:0];
				CFG_CAPACITY:      cfg_q.payload_capacity    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_beat.rx_byte   = rx_byte;
	assign in_beat.timed_out = timed_out;

	sofr_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_beat    (in_beat),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat)
	);

	sofr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.beat       (beat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	assign result_kind    = result.kind;
	assign payload_byte   = result.payload_byte;
	assign frame_type     = result.frame_type;
	assign frame_flags    = result.frame_flags;
	assign frame_sequence = result.frame_sequence;
	assign frame_length   = result.frame_length;
	assign error_code     = result.error_code;

endmodule

// ===== hw/rtl/sofr_checker.sv =====
// ----------------------------------------------------------------------------
// sofr_checker
// Port-level checks on the frame receiver's result channel.
// ----------------------------------------------------------------------------
module sofr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [7:0]  payload_byte,
	input logic [2:0]  error_code
);
	import sofr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
			$stable(payload_byte) && $stable(error_code))
		else $error("result beat changed while stalled");

	a_payload_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD |-> error_code == ERR_NONE)
		else $error("payload beat carries an error code");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ACCEPT |-> error_code == ERR_NONE &&
			payload_byte == 8'h00)
		else $error("accept verdict not clean");

	a_reject_coded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_REJECT |-> error_code != ERR_NONE &&
			payload_byte == 8'h00)
		else $error("reject verdict without error code");

	a_result_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an input beat two cycles earlier");

endmodule

bind sof_length_crc_frame_receiver_unit sofr_checker u_sofr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_kind  (result_kind),
	.payload_byte (payload_byte),
	.error_code   (error_code)
);

// ===== tb/sv/frame_rx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rx_checker
// Watches the byte, result and register ports of the frame receiver. Every
// accepted byte beat runs through a local deframer model (hunt, header, payload,
// CRC) that queues the result beats it implies; every accepted result beat is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module frame_rx_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        timed_out,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  frame_type,
	input  logic [7:0]  frame_flags,
	input  logic [7:0]  frame_sequence,
	input  logic [15:0] frame_length,
	input  logic [2:0]  error_code,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);
	import sofr_pkg::*;

	logic [7:0]  marker_a;
	logic [7:0]  marker_b;
	logic [7:0]  want_version;
	logic [15:0] capacity;

	phase_t      rx_state;
	logic [2:0]  hdr_count;
	logic [47:0] hdr_bytes;
	logic [15:0] bytes_left;
	logic [15:0] hdr_crc;
	logic [15:0] pay_crc;
	logic [7:0]  wire_crc_lo;

	result_t     predicted_beats[$];
	result_t     want_r;
	int          n_bad = 0;

	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ 16'h1021;
			end
		end
		return c;
	endfunction

	function automatic result_t frame_result(input kind_t k, input logic [7:0] pb, input err_t e);
		result_t r;
		r.kind           = k;
		r.payload_byte   = pb;
		r.frame_type     = hdr_bytes[15:8];
		r.frame_flags    = hdr_bytes[23:16];
		r.frame_sequence = hdr_bytes[31:24];
		r.frame_length   = hdr_bytes[47:32];
		r.error_code     = e;
		return r;
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b, input logic tmo);
		logic [15:0] calc;
		if (tmo) begin
			if (rx_state != PH_HUNT && rx_state != PH_SECOND) begin
				predicted_beats.push_back(frame_result(KIND_REJECT, 8'h00, ERR_TIMEOUT));
			end
			rx_state = PH_HUNT;
		end else begin
			case (rx_state)
				PH_HUNT: begin
					if (b == marker_a) begin
						rx_state = PH_SECOND;
					end
				end
				PH_SECOND: begin
					if (b == marker_b) begin
						rx_state   = PH_HEADER;
						hdr_count  = 3'd0;
						hdr_bytes  = '0;
						bytes_left = '0;
						hdr_crc    = 16'hFFFF;
						pay_crc    = 16'hFFFF;
					end else begin
						rx_state = PH_HUNT;
					end
				end
				PH_HEADER: begin
					hdr_bytes[8 * hdr_count +: 8] = b;
					hdr_crc = crc16_feed(hdr_crc, b);
					if (hdr_count != HDR_LAST) begin
						hdr_count++;
					end else begin
						hdr_count = 3'd0;
						if (hdr_bytes[7:0] != want_version) begin
							rx_state = PH_HUNT;
							predicted_beats.push_back(frame_result(KIND_REJECT, 8'h00, ERR_VERSION));
						end else if (hdr_bytes[47:32] > capacity) begin
							rx_state = PH_HUNT;
							predicted_beats.push_back(frame_result(KIND_REJECT, 8'h00, ERR_LENGTH));
						end else begin
							bytes_left = hdr_bytes[47:32];
							if (bytes_left != 16'd0) begin
								rx_state = PH_PAYLOAD;
							end else begin
								rx_state = PH_CRC_LO;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					pay_crc    = crc16_feed(pay_crc, b);
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 16'd0) begin
						rx_state = PH_CRC_LO;
					end
					predicted_beats.push_back(frame_result(KIND_PAYLOAD, b, ERR_NONE));
				end
				PH_CRC_LO: begin
					wire_crc_lo = b;
					rx_state    = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					calc = hdr_crc;
					if (hdr_bytes[47:32] != 16'd0) begin
						calc = calc ^ pay_crc;
					end
					rx_state = PH_HUNT;
					if (calc == {b, wire_crc_lo}) begin
						predicted_beats.push_back(frame_result(KIND_ACCEPT, 8'h00, ERR_NONE));
					end else begin
						predicted_beats.push_back(frame_result(KIND_REJECT, 8'h00, ERR_CRC));
					end
				end
				default: begin
					rx_state = PH_HUNT;
				end
			endcase
		end
	endtask

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
			n_bad++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			marker_a     = 8'h00;
			marker_b     = 8'h00;
			want_version = 8'h01;
			capacity     = 16'hFFFF;
			rx_state     = PH_HUNT;
			hdr_count    = 3'd0;
			hdr_bytes    = '0;
			bytes_left   = '0;
			hdr_crc      = 16'hFFFF;
			pay_crc      = 16'hFFFF;
			wire_crc_lo  = 8'h00;
			predicted_beats.delete();
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_MARKER_FIRST:  marker_a     = cfg_data[7:0];
					CFG_MARKER_SECOND: marker_b     = cfg_data[7:0];
					CFG_VERSION:       want_version = cfg_data[7:0];
					CFG_CAPACITY:      capacity     = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (predicted_beats.size() == 0) begin
					$display("%0t ns: result beat with none expected, got kind %0d error %0d",
						$time, result_kind, error_code);
					n_bad++;
				end else begin
					want_r = predicted_beats.pop_front();
					check_field("result_kind", want_r.kind, result_kind);
					check_field("payload_byte", want_r.payload_byte, payload_byte);
					check_field("frame_type", want_r.frame_type, frame_type);
					check_field("frame_flags", want_r.frame_flags, frame_flags);
					check_field("frame_sequence", want_r.frame_sequence, frame_sequence);
					check_field("frame_length", want_r.frame_length, frame_length);
					check_field("error_code", want_r.error_code, error_code);
				end
			end
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte, timed_out);
			end
		end
		outstanding <= predicted_beats.size();
		fail_count  <= n_bad;
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the start-marker / length / CRC frame receiver: a short directed
// opener, then framed traffic (clean, bad CRC, bad version, over capacity, cut
// by timeout, broken marker pairs) mixed with line noise, across several
// register settings, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_top;
	import sofr_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_TARGET   = 1875;
	localparam int NUM_PHASES    = 6;
	localparam int LONG_LEN      = 300;
	localparam int WATCHDOG_NS   = 4_000_000;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_RANDOM,
		SINK_SLOW,
		SINK_PERIODIC
	} sink_mode_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte      = 8'h00;
	logic        timed_out    = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  frame_type;
	logic [7:0]  frame_flags;
	logic [7:0]  frame_sequence;
	logic [15:0] frame_length;
	logic [2:0]  error_code;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index    = CFG_MARKER_FIRST;
	logic [15:0] cfg_data     = 16'h0000;

	int          fail_count;
	int          outstanding;

	logic [7:0]  sof_a       = 8'h00;
	logic [7:0]  sof_b       = 8'h00;
	logic [7:0]  cur_version = 8'h01;
	logic [15:0] cur_cap     = 16'hFFFF;
	logic [7:0]  frame_q[$];
	int          burst_left  = 0;
	int          beat_total  = 0;

	sink_mode_t  sink_mode   = SINK_FREE;
	int          mode_left   = 0;
	int          sink_cycle  = 0;

	sof_length_crc_frame_receiver_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.timed_out      (timed_out),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.payload_byte   (payload_byte),
		.frame_type     (frame_type),
		.frame_flags    (frame_flags),
		.frame_sequence (frame_sequence),
		.frame_length   (frame_length),
		.error_code     (error_code),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	frame_rx_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.timed_out      (timed_out),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.payload_byte   (payload_byte),
		.frame_type     (frame_type),
		.frame_flags    (frame_flags),
		.frame_sequence (frame_sequence),
		.frame_length   (frame_length),
		.error_code     (error_code),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		sink_cycle <= sink_cycle + 1;
		if (mode_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (sink_mode)
			SINK_FREE:     out_ready <= 1'b1;
			SINK_RANDOM:   out_ready <= $urandom_range(0, 1);
			SINK_SLOW:     out_ready <= ($urandom_range(0, 3) == 0);
			SINK_PERIODIC: out_ready <= (sink_cycle % 5) != 0;
			default:       out_ready <= 1'b1;
		endcase
	end

	// byte-wise CCITT update, shift-and-fold form
	function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0]  x;
		logic [15:0] w;
		x = crc[15:8] ^ b;
		x = x ^ (x >> 4);
		w = {8'h00, x};
		return {crc[7:0], 8'h00} ^ (w << 12) ^ (w << 5) ^ w;
	endfunction

	function automatic logic [15:0] pick_length();
		int r;
		int top;
		r = $urandom_range(0, 99);
		if (r < 10 || cur_cap == 16'd0) begin
			return 16'd0;
		end
		if (r < 80) begin
			top = 12;
		end else if (r < 96) begin
			top = 80;
		end else if (r < 98) begin
			top = LONG_LEN;
		end else begin
			return cur_cap;
		end
		if (top > int'(cur_cap)) begin
			top = cur_cap;
		end
		return 16'($urandom_range(1, top));
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic tmo);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		rx_byte   <= b;
		timed_out <= tmo;
		do @(posedge clk); while (!in_ready);
		beat_total++;
	endtask

	// hold off input until every queued result has drained
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_receiver(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] ver, input logic [15:0] cap);
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_MARKER_FIRST;
		cfg_data     <= {8'($urandom_range(0, 255)), a};
		@(posedge clk);
		cfg_index    <= CFG_MARKER_SECOND;
		cfg_data     <= {8'($urandom_range(0, 255)), b};
		@(posedge clk);
		cfg_index    <= CFG_VERSION;
		cfg_data     <= {8'($urandom_range(0, 255)), ver};
		@(posedge clk);
		cfg_index    <= CFG_CAPACITY;
		cfg_data     <= cap;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sof_a       = a;
		sof_b       = b;
		cur_version = ver;
		cur_cap     = cap;
	endtask

	// header, payload and trailing CRC of one frame, markers not included
	task automatic build_frame(input logic [7:0] ver, input logic [15:0] len,
			input logic [15:0] flip);
		logic [15:0] hcrc;
		logic [15:0] pcrc;
		logic [7:0]  b;
		int          body;
		frame_q.delete();
		frame_q.push_back(ver);
		repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(len[7:0]);
		frame_q.push_back(len[15:8]);
		hcrc = 16'hFFFF;
		pcrc = 16'hFFFF;
		for (int i = 0; i < 6; i++) begin
			hcrc = ccitt_next(hcrc, frame_q[i]);
		end
		body = (int'(len) > LONG_LEN) ? $urandom_range(0, 16) : int'(len);
		for (int i = 0; i < body; i++) begin
			b = 8'($urandom_range(0, 255));
			frame_q.push_back(b);
			pcrc = ccitt_next(pcrc, b);
		end
		if (len != 16'd0) begin
			hcrc = hcrc ^ pcrc;
		end
		hcrc = hcrc ^ flip;
		frame_q.push_back(hcrc[7:0]);
		frame_q.push_back(hcrc[15:8]);
	endtask

	task automatic send_frame(input int count, input logic cut);
		send_beat(sof_a, 1'b0);
		send_beat(sof_b, 1'b0);
		for (int i = 0; i < count; i++) begin
			send_beat(frame_q[i], 1'b0);
		end
		if (cut) begin
			send_beat(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic line_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic random_frame();
		int          pick;
		int          count;
		logic        cut;
		logic [15:0] len;
		logic [15:0] flip;
		logic [7:0]  ver;
		logic [7:0]  wrong;
		pick  = $urandom_range(0, 99);
		len   = pick_length();
		ver   = cur_version;
		flip  = 16'h0000;
		count = -1;
		cut   = 1'b0;
		if (pick < 50) begin
		end else if (pick < 62) begin
			flip = 16'($urandom_range(1, 65535));
		end else if (pick < 70) begin
			ver = cur_version ^ 8'($urandom_range(1, 255));
			if ($urandom_range(0, 1)) begin
				len = 16'($urandom_range(0, 65535));
			end
			count = 6;
		end else if (pick < 78) begin
			if (cur_cap != 16'hFFFF) begin
				len   = 16'($urandom_range(int'(cur_cap) + 1, 65535));
				count = 6;
			end
		end else if (pick < 92) begin
			cut = 1'b1;
		end else begin
			send_beat(sof_a, 1'b0);
			if (sof_a != sof_b && $urandom_range(0, 1)) begin
				wrong = sof_a;
			end else begin
				do wrong = 8'($urandom_range(0, 255)); while (wrong == sof_b);
			end
			send_beat(wrong, 1'b0);
			return;
		end
		build_frame(ver, len, flip);
		if (count < 0) begin
			count = frame_q.size();
			if (int'(len) > LONG_LEN) begin
				cut = 1'b1;
			end
		end
		if (cut) begin
			count = $urandom_range(0, count - 1);
		end
		send_frame(count, cut);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// timeout while hunting, then while waiting for the second marker
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		send_beat(sof_a, 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		// broken marker pair
		send_beat(sof_a, 1'b0);
		send_beat(8'hFF, 1'b0);
		// empty frame, then bad version carrying the largest length
		build_frame(cur_version, 16'd0, 16'h0000);
		send_frame(frame_q.size(), 1'b0);
		build_frame(cur_version ^ 8'hFF, 16'hFFFF, 16'h0000);
		send_frame(6, 1'b0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				send_beat(8'($urandom_range(0, 255)), 1'b1);
				drain_results();
				case (p)
					1: program_receiver(8'hFF, 8'h00, 8'hFF, 16'h0000);
					2: program_receiver(8'h00, 8'hFF, 8'h00, 16'hFFFF);
					3: program_receiver(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 16'($urandom_range(1, 40)));
					4: begin
						sof_a = 8'($urandom_range(0, 255));
						program_receiver(sof_a, sof_a, 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65535)));
					end
					default: program_receiver(8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd300);
				endcase
			end
			while (beat_total < (p + 1) * ITEM_TARGET / NUM_PHASES) begin
				if ($urandom_range(0, 9) == 0) begin
					line_noise();
				end else begin
					random_frame();
				end
			end
		end

		drain_results();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
